// ----- src/ffba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg: shared definitions of the first-fit bitmap allocator
// Pool geometry, busy-map word layout, derived widths, controller states and
// the result record that the chunk scanner hands to the controller.
// ----------------------------------------------------------------------------
package ffba_pkg;

   // pool size in allocation units
   localparam int POOL_UNITS = 1024;

   // request and response field widths
   localparam int START_W  = 10;
   localparam int LENGTH_W = 11;

   // busy map word layout: one bit per unit, scanned one chunk per cycle
   localparam int WORD_BITS   = 32;
   localparam int WORD_IDX_W  = $clog2(WORD_BITS);
   localparam int CHUNK_BITS  = 8;
   localparam int BIT_IDX_W   = $clog2(CHUNK_BITS);
   localparam int CHUNKS      = WORD_BITS / CHUNK_BITS;
   localparam int CHUNK_IDX_W = $clog2(CHUNKS);

   // memory depth and derived index widths
   localparam int NUM_WORDS = (POOL_UNITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int UNIT_W    = WADDR_W + WORD_IDX_W;
   localparam int CNT_W     = $clog2(POOL_UNITS + 1);

   // common width for unit arithmetic and compares against lengths
   localparam int MAX_A = (CNT_W > UNIT_W) ? CNT_W : UNIT_W;
   localparam int MAX_B = (MAX_A > LENGTH_W) ? MAX_A : LENGTH_W;
   localparam int VAL_W = MAX_B + 1;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_DONE
   } fsm_state_type;

   // outcome of scanning one chunk of the busy map
   typedef struct packed {
      logic              hit;
      logic [UNIT_W-1:0] hit_unit;
      logic [VAL_W-1:0]  run;
   } scan_result_type;

endpackage

// ----- src/ffba_map_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_map_ram: busy map storage
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read is issued and holds until the next read.
// ----------------------------------------------------------------------------
module ffba_map_ram
   import ffba_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [WADDR_W-1:0]   wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [WADDR_W-1:0]   rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   // write the addressed word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // register the read word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ffba_chunk_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_chunk_scan: first-fit step over one chunk of the busy map
// Extends the running count of free units across one chunk and reports the
// first unit at which the count reaches the requested length.
// ----------------------------------------------------------------------------
module ffba_chunk_scan
   import ffba_pkg::*;
(
   input  logic [CHUNK_BITS-1:0] chunk_bits,
   input  logic [UNIT_W-1:0]     base_unit,
   input  logic [VAL_W-1:0]      run_in,
   input  logic [VAL_W-1:0]      run_length,
   output scan_result_type       result
);

   always_comb begin
      logic [VAL_W-1:0]  run_v;
      logic [UNIT_W-1:0] unit_v;
      logic              busy_v;
      logic              hit_v;
      logic [UNIT_W-1:0] hit_unit_v;
      run_v      = run_in;
      hit_v      = 1'b0;
      hit_unit_v = '0;
      // walk the chunk low bit first; units past the pool end count as busy
      for (int b = 0; b < CHUNK_BITS; b++) begin
         unit_v = {base_unit[UNIT_W-1:BIT_IDX_W], BIT_IDX_W'(b)};
         busy_v = chunk_bits[b] || (VAL_W'(unit_v) >= VAL_W'(POOL_UNITS));
         if (!hit_v) begin
            if (busy_v) begin
               run_v = '0;
            end else begin
               run_v = run_v + VAL_W'(1);
               if (run_v == run_length) begin
                  hit_v      = 1'b1;
                  hit_unit_v = unit_v;
               end
            end
         end
      end
      result.hit      = hit_v;
      result.hit_unit = hit_unit_v;
      result.run      = run_v;
   end

endmodule

// ----- src/first_fit_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_bitmap_allocator: first-fit run allocator over a busy bitmap
// Keeps one busy bit per pool unit in a word-wide memory; allocates the
// lowest free run of a requested length and frees runs on request.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives one response. After reset the
// block sweeps the busy map to zero, one word per cycle over NUM_WORDS = 32
// words at the default pool, and stalls requests meanwhile. An allocate
// reads the map one 32-bit word at a time and scans it one 8-unit chunk per
// cycle up to the end of the granted run or of the map; it then marks the
// run with a pipelined read-modify-write sweep over each touched word. A
// free runs that sweep alone. Zero-length requests and oversized allocates
// skip the map and go straight to the response. The chunk scanner sets the
// search rate; the read-modify-write sweep sets the marking rate. A finished
// response waits in an output register.
// ----------------------------------------------------------------------------
module first_fit_bitmap_allocator
   import ffba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [START_W-1:0]  req_run_start,
   input  logic [LENGTH_W-1:0] req_run_length,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_status,
   output logic [START_W-1:0]  rsp_granted_start
);

   // control registers
   fsm_state_type        state_ff, state_in;
   logic [WADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [WADDR_W-1:0]   word_ff, word_in;
   logic [CHUNK_IDX_W-1:0] chunk_ff, chunk_in;
   logic [WADDR_W-1:0]   sw_addr_ff, sw_addr_in;
   logic                 sw_more_ff, sw_more_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // working registers
   logic                 op_free_ff, op_free_in;
   logic [VAL_W-1:0]     len_ff, len_in;
   logic [VAL_W-1:0]     run_ff, run_in;
   logic [UNIT_W-1:0]    lo_ff, lo_in;
   logic [UNIT_W-1:0]    hi_ff, hi_in;
   logic [WADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic                 status_ff, status_in;
   logic [START_W-1:0]   gstart_ff, gstart_in;
   logic                 rsp_status_ff;
   logic [START_W-1:0]   rsp_granted_start_ff;

   // memory port signals
   logic                 ram_wr_en;
   logic [WADDR_W-1:0]   ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [WADDR_W-1:0]   ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   // datapath signals
   logic                  accept;
   logic                  rsp_load;
   logic [VAL_W-1:0]      req_len_v;
   logic [VAL_W-1:0]      req_start_v;
   logic [VAL_W-1:0]      free_end;
   logic                  free_over;
   logic                  free_none;
   logic [CHUNK_BITS-1:0] chunk_bits;
   logic [UNIT_W-1:0]     chunk_base;
   scan_result_type       scan;
   logic [VAL_W-1:0]      hit_first;
   logic [UNIT_W-1:0]     hit_lo;
   logic [WORD_BITS-1:0]  sweep_mask;

   ffba_map_ram u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // select the chunk under scan and its first unit
   assign chunk_bits = CHUNK_BITS'(ram_rd_data >> {chunk_ff, BIT_IDX_W'(0)});
   assign chunk_base = {word_ff, chunk_ff, BIT_IDX_W'(0)};

   ffba_chunk_scan u_chunk_scan (
      .chunk_bits (chunk_bits),
      .base_unit  (chunk_base),
      .run_in     (run_ff),
      .run_length (len_ff),
      .result     (scan)
   );

   // start of the run found by the scanner
   assign hit_first = VAL_W'(scan.hit_unit) + VAL_W'(1) - len_ff;
   assign hit_lo    = UNIT_W'(hit_first);

   // decode the free range of the incoming request
   assign req_len_v   = VAL_W'(req_run_length);
   assign req_start_v = VAL_W'(req_run_start);
   assign free_end    = req_start_v + req_len_v;
   assign free_over   = (req_run_length != '0) && (free_end > VAL_W'(POOL_UNITS));
   assign free_none   = (req_run_length == '0) || (req_start_v >= VAL_W'(POOL_UNITS));

   // mark the units of the sweep range inside the word being written
   always_comb begin
      logic [UNIT_W-1:0] unit_v;
      for (int b = 0; b < WORD_BITS; b++) begin
         unit_v = {wr_addr_ff, WORD_IDX_W'(b)};
         sweep_mask[b] = (unit_v >= lo_ff) && (unit_v <= hi_ff);
      end
   end

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   // hold the state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         word_ff      <= '0;
         chunk_ff     <= '0;
         sw_addr_ff   <= '0;
         sw_more_ff   <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         word_ff      <= word_in;
         chunk_ff     <= chunk_in;
         sw_addr_ff   <= sw_addr_in;
         sw_more_ff   <= sw_more_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the working registers
   always_ff @(posedge clock) begin
      op_free_ff <= op_free_in;
      len_ff     <= len_in;
      run_ff     <= run_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      wr_addr_ff <= wr_addr_in;
      status_ff  <= status_in;
      gstart_ff  <= gstart_in;
      if (rsp_load) begin
         rsp_status_ff        <= status_ff;
         rsp_granted_start_ff <= gstart_ff;
      end
   end

   // sequence clearing, scanning, sweeping and response hand-off
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      word_in      = word_ff;
      chunk_in     = chunk_ff;
      sw_addr_in   = sw_addr_ff;
      sw_more_in   = sw_more_ff;
      wr_pend_in   = wr_pend_ff;
      op_free_in   = op_free_ff;
      len_in       = len_ff;
      run_in       = run_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      wr_addr_in   = wr_addr_ff;
      status_in    = status_ff;
      gstart_in    = gstart_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_addr_ff;
      ram_wr_data  = op_free_ff ? (ram_rd_data & ~sweep_mask) : (ram_rd_data | sweep_mask);
      ram_rd_en    = 1'b0;
      ram_rd_addr  = sw_addr_ff;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // zero one map word per cycle
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + WADDR_W'(1);
            if (clr_addr_ff == WADDR_W'(NUM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               op_free_in = (req_cmd == CMD_FREE);
               len_in     = req_len_v;
               run_in     = '0;
               word_in    = '0;
               chunk_in   = '0;
               gstart_in  = '0;
               wr_pend_in = 1'b0;
               sw_more_in = 1'b1;
               if (req_cmd == CMD_ALLOC) begin
                  if (req_run_length == '0) begin
                     status_in = STATUS_OK;
                     state_in  = ST_DONE;
                  end else if (req_len_v > VAL_W'(POOL_UNITS)) begin
                     status_in = STATUS_FAIL;
                     state_in  = ST_DONE;
                  end else begin
                     // fetch the first map word for the scan
                     status_in   = STATUS_OK;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = ST_SCAN;
                  end
               end else begin
                  status_in = free_over ? STATUS_FAIL : STATUS_OK;
                  if (free_none) begin
                     state_in = ST_DONE;
                  end else begin
                     lo_in = UNIT_W'(req_start_v);
                     if (free_over) begin
                        hi_in = UNIT_W'(VAL_W'(POOL_UNITS - 1));
                     end else begin
                        hi_in = UNIT_W'(free_end - VAL_W'(1));
                     end
                     sw_addr_in = lo_in[UNIT_W-1:WORD_IDX_W];
                     state_in   = ST_SWEEP;
                  end
               end
            end
         end

         ST_SCAN: begin
            if (scan.hit) begin
               // run found: mark it busy
               lo_in      = hit_lo;
               hi_in      = scan.hit_unit;
               gstart_in  = START_W'(hit_first);
               status_in  = STATUS_OK;
               sw_addr_in = hit_lo[UNIT_W-1:WORD_IDX_W];
               state_in   = ST_SWEEP;
            end else begin
               run_in   = scan.run;
               chunk_in = chunk_ff + CHUNK_IDX_W'(1);
               if (chunk_ff == CHUNK_IDX_W'(CHUNKS - 1)) begin
                  if (word_ff == WADDR_W'(NUM_WORDS - 1)) begin
                     status_in = STATUS_FAIL;
                     gstart_in = '0;
                     state_in  = ST_DONE;
                  end else begin
                     // advance to the next map word
                     word_in     = word_ff + WADDR_W'(1);
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = word_ff + WADDR_W'(1);
                  end
               end
            end
         end

         ST_SWEEP: begin
            // write back the word read last cycle
            ram_wr_en = wr_pend_ff;
            if (sw_more_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = sw_addr_ff;
               wr_pend_in  = 1'b1;
               wr_addr_in  = sw_addr_ff;
               if (sw_addr_ff == hi_ff[UNIT_W-1:WORD_IDX_W]) begin
                  sw_more_in = 1'b0;
               end else begin
                  sw_addr_in = sw_addr_ff + WADDR_W'(1);
               end
            end else begin
               wr_pend_in = 1'b0;
               state_in   = ST_DONE;
            end
         end

         ST_DONE: begin
            // transfer into the response register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // track the response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_start = rsp_granted_start_ff;

endmodule
